>>> rtl/mqts_pkg.sv
// ----------------------------------------------------------------------------
// mqts_pkg: shared types and constants for the two-stack min queue
// Command and status codes, field widths and the default queue depth.
// ----------------------------------------------------------------------------
package mqts_pkg;

    localparam int unsigned DATA_W        = 32;
    localparam int unsigned CMD_W         = 3;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned DEPTH_DEFAULT = 1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_DEQUEUE = 3'd1,
        CMD_FRONT   = 3'd2,
        CMD_MIN     = 3'd3,
        CMD_SIZE    = 3'd4,
        CMD_CLEAR   = 3'd5
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK   = 2'd0,
        ST_ERR  = 2'd1,
        ST_DATA = 2'd2
    } status_t;

endpackage

>>> rtl/min_queue_two_stacks.sv
// ----------------------------------------------------------------------------
// min_queue_two_stacks: FIFO queue of signed values with running minimum
// Built from an input stack and an output stack, each with a running-minimum
// memory; one shared signed compare unit serves enqueue, min and transfer.
// ----------------------------------------------------------------------------
// Sequence: an accepted command passes S_READ, then S_EXEC; done pulses as the
// block returns to S_IDLE. busy stays high until then, so one command is handled at a time.
// A dequeue with an empty output stack first moves all n input entries in
// S_XFER, one per cycle through the memory read port, then passes S_READ again.
// Reset clears both stack counts; the stack memories are not cleared.
// Results cannot be stalled: done is high for one cycle only per result.
module min_queue_two_stacks #(
    parameter int unsigned DEPTH = mqts_pkg::DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mqts_pkg::CMD_W-1:0]          command,
    input  logic signed [mqts_pkg::DATA_W-1:0]  value,
    output logic                                done,
    output logic [mqts_pkg::STATUS_W-1:0]       status,
    output logic signed [mqts_pkg::DATA_W-1:0]  data,
    output logic [$clog2(DEPTH+1)-1:0]          count
);

    import mqts_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_XFER,
        S_EXEC
    } state_t;

    typedef logic signed [DATA_W-1:0] word_t;

    // stack memories
    word_t in_values  [DEPTH];
    word_t in_mins    [DEPTH];
    word_t out_values [DEPTH];
    word_t out_mins   [DEPTH];

    // control and result registers
    state_t          state_reg,     state_next;
    cmd_t            cmd_reg,       cmd_next;
    word_t           val_reg,       val_next;
    logic [CW-1:0]   in_count_reg,  in_count_next;
    logic [CW-1:0]   out_count_reg, out_count_next;
    logic            pend_reg,      pend_next;
    word_t           run_min_reg,   run_min_next;
    logic            done_reg,      done_next;
    status_t         status_reg,    status_next;
    word_t           data_reg,      data_next;
    logic [CW-1:0]   count_reg,     count_next;

    // registered memory read data
    word_t in_val_rd_reg;
    word_t in_min_rd_reg;
    word_t out_val_rd_reg;
    word_t out_min_rd_reg;

    logic [CW-1:0]   in_count_m1;
    logic [CW-1:0]   out_count_m1;
    logic [CW-1:0]   total;
    logic [AW-1:0]   in_rd_addr;
    logic [AW-1:0]   out_rd_addr;
    logic            in_wr_en;
    word_t           in_wr_min;
    logic            out_wr_en;
    word_t           out_wr_min;

    // shared compare unit
    word_t           cmp_a;
    word_t           cmp_b;
    word_t           cmp_min;

    assign in_count_m1  = in_count_reg - CW'(1);
    assign out_count_m1 = out_count_reg - CW'(1);
    assign total        = in_count_reg + out_count_reg;
    assign out_rd_addr  = out_count_m1[AW-1:0];
    assign in_rd_addr   = (state_reg == S_READ && cmd_reg == CMD_FRONT) ? '0
                                                                     : in_count_m1[AW-1:0];

    always_comb
    begin
        unique case (state_reg)
            S_XFER:
            begin
                cmp_a = run_min_reg;
                cmp_b = in_val_rd_reg;
            end
            S_EXEC:
            begin
                if (cmd_reg == CMD_ENQUEUE)
                begin
                    cmp_a = val_reg;
                    cmp_b = in_min_rd_reg;
                end
                else
                begin
                    cmp_a = in_min_rd_reg;
                    cmp_b = out_min_rd_reg;
                end
            end
            default:
            begin
                cmp_a = in_min_rd_reg;
                cmp_b = out_min_rd_reg;
            end
        endcase
        cmp_min = (cmp_b < cmp_a) ? cmp_b : cmp_a;
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        val_next       = val_reg;
        in_count_next  = in_count_reg;
        out_count_next = out_count_reg;
        pend_next      = pend_reg;
        run_min_next   = run_min_reg;
        done_next      = 1'b0;
        status_next    = status_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        in_wr_en       = 1'b0;
        in_wr_min      = val_reg;
        out_wr_en      = 1'b0;
        out_wr_min     = in_val_rd_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = cmd_t'(command);
                    val_next   = value;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                pend_next = 1'b0;
                if (cmd_reg == CMD_DEQUEUE && out_count_reg == '0 && in_count_reg != '0)
                    state_next = S_XFER;
                else
                    state_next = S_EXEC;
            end
            S_XFER:
            begin
                // write the entry read last cycle, issue the next read
                if (pend_reg)
                begin
                    out_wr_en      = 1'b1;
                    out_wr_min     = (out_count_reg == '0) ? in_val_rd_reg : cmp_min;
                    run_min_next   = out_wr_min;
                    out_count_next = out_count_reg + CW'(1);
                end
                if (in_count_reg != '0)
                begin
                    in_count_next = in_count_m1;
                    pend_next     = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                        state_next = S_READ;
                end
            end
            S_EXEC:
            begin
                status_next = ST_ERR;
                data_next   = '0;
                unique case (cmd_reg)
                    CMD_ENQUEUE:
                    begin
                        if (total < DEPTH_C)
                        begin
                            in_wr_en      = 1'b1;
                            in_wr_min     = (in_count_reg == '0) ? val_reg : cmp_min;
                            in_count_next = in_count_reg + CW'(1);
                            status_next   = ST_OK;
                        end
                    end
                    CMD_DEQUEUE:
                    begin
                        if (total != '0)
                        begin
                            out_count_next = out_count_m1;
                            data_next      = out_val_rd_reg;
                            status_next    = ST_DATA;
                        end
                    end
                    CMD_FRONT:
                    begin
                        if (total != '0)
                        begin
                            data_next   = (out_count_reg == '0) ? in_val_rd_reg
                                                                : out_val_rd_reg;
                            status_next = ST_DATA;
                        end
                    end
                    CMD_MIN:
                    begin
                        if (total != '0)
                        begin
                            if (in_count_reg == '0)
                                data_next = out_min_rd_reg;
                            else if (out_count_reg == '0)
                                data_next = in_min_rd_reg;
                            else
                                data_next = cmp_min;
                            status_next = ST_DATA;
                        end
                    end
                    CMD_SIZE:
                    begin
                        status_next = ST_OK;
                    end
                    CMD_CLEAR:
                    begin
                        in_count_next  = '0;
                        out_count_next = '0;
                        status_next    = ST_OK;
                    end
                    default:
                    begin
                        status_next = ST_ERR;
                    end
                endcase
                count_next = in_count_next + out_count_next;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_SIZE;
            val_reg       <= '0;
            in_count_reg  <= '0;
            out_count_reg <= '0;
            pend_reg      <= 1'b0;
            run_min_reg   <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            data_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            val_reg       <= val_next;
            in_count_reg  <= in_count_next;
            out_count_reg <= out_count_next;
            pend_reg      <= pend_next;
            run_min_reg   <= run_min_next;
            done_reg      <= done_next;
            status_reg    <= status_next;
            data_reg      <= data_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_wr_en)
        begin
            in_values[in_count_reg[AW-1:0]] <= val_reg;
            in_mins[in_count_reg[AW-1:0]]   <= in_wr_min;
        end
        in_val_rd_reg <= in_values[in_rd_addr];
        in_min_rd_reg <= in_mins[in_rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (out_wr_en)
        begin
            out_values[out_count_reg[AW-1:0]] <= in_val_rd_reg;
            out_mins[out_count_reg[AW-1:0]]   <= out_wr_min;
        end
        out_val_rd_reg <= out_values[out_rd_addr];
        out_min_rd_reg <= out_mins[out_rd_addr];
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign status = status_reg;
    assign data   = data_reg;
    assign count  = count_reg;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg != ST_DATA) |-> (data == '0))
        else $error("data nonzero on a result without data");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (total <= DEPTH_C) && (count_reg <= DEPTH_C))
        else $error("queue occupancy beyond depth");
`endif

endmodule

>>> bench/min_queue_two_stacks_test.sv
// ----------------------------------------------------------------------------
// min_queue_two_stacks_test: self-checking bench for the two-stack min queue
// Walks a directed table covering the empty-queue errors, unknown commands,
// the signed extremes and an input-to-output transfer. Random command mixes
// follow, plus one fill to full depth, with random sender idle bursts.
// Every result is checked against a fixed row or a model of the two stacks.
// ----------------------------------------------------------------------------
module min_queue_two_stacks_test;

    import mqts_pkg::*;

    localparam int unsigned DEPTH          = DEPTH_DEFAULT;
    localparam int unsigned CNT_W          = $clog2(DEPTH + 1);
    localparam int          ITEM_TOTAL     = 1750;
    localparam int          FILL_AT        = 500;
    localparam int          CALM_TAIL      = 150;
    localparam int          WATCHDOG_LIMIT = 8192;
    localparam int          DIRECTED_ROWS  = 26;

    localparam logic [CMD_W-1:0] CMD_UNKNOWN6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN7 = 3'd7;

    typedef struct packed {
        status_t                  status;
        logic signed [DATA_W-1:0] data;
        logic [CNT_W-1:0]         count;
    } queue_result_t;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] val;
        logic              fixed;
        status_t           status;
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
    } stim_row_t;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         command;
    logic signed [DATA_W-1:0] value;
    logic                     done;
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         count;

    logic signed [DATA_W-1:0] in_vals  [DEPTH];
    logic signed [DATA_W-1:0] in_mins  [DEPTH];
    logic signed [DATA_W-1:0] out_vals [DEPTH];
    logic signed [DATA_W-1:0] out_mins [DEPTH];
    int                       in_cnt;
    int                       out_cnt;

    queue_result_t results_due [$];
    stim_row_t     directed_rows [DIRECTED_ROWS];
    int            mismatches;
    int            sent;
    int            idle_rate;
    int            quiet_cycles;

    min_queue_two_stacks #(
        .DEPTH (DEPTH)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .command (command),
        .value   (value),
        .done    (done),
        .status  (status),
        .data    (data),
        .count   (count)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic logic signed [DATA_W-1:0] smaller(input logic signed [DATA_W-1:0] a,
                                                         input logic signed [DATA_W-1:0] b);
        return (b < a) ? b : a;
    endfunction

    task automatic queue_step(input logic [CMD_W-1:0] cmd, input logic signed [DATA_W-1:0] val,
                              output queue_result_t res);
        int total;
        total = in_cnt + out_cnt;
        res.status = ST_ERR;
        res.data   = '0;
        case (cmd)
            CMD_ENQUEUE:
            begin
                if (total < DEPTH)
                begin
                    in_vals[in_cnt] = val;
                    in_mins[in_cnt] = (in_cnt == 0) ? val : smaller(val, in_mins[in_cnt-1]);
                    in_cnt++;
                    res.status = ST_OK;
                end
            end
            CMD_DEQUEUE:
            begin
                if (total != 0)
                begin
                    if (out_cnt == 0)
                    begin
                        while (in_cnt > 0)
                        begin
                            in_cnt--;
                            out_vals[out_cnt] = in_vals[in_cnt];
                            out_mins[out_cnt] = (out_cnt == 0) ? in_vals[in_cnt]
                                              : smaller(in_vals[in_cnt], out_mins[out_cnt-1]);
                            out_cnt++;
                        end
                    end
                    out_cnt--;
                    res.data   = out_vals[out_cnt];
                    res.status = ST_DATA;
                end
            end
            CMD_FRONT:
            begin
                if (total != 0)
                begin
                    res.data   = (out_cnt == 0) ? in_vals[0] : out_vals[out_cnt-1];
                    res.status = ST_DATA;
                end
            end
            CMD_MIN:
            begin
                if (total != 0)
                begin
                    if (in_cnt == 0)
                        res.data = out_mins[out_cnt-1];
                    else if (out_cnt == 0)
                        res.data = in_mins[in_cnt-1];
                    else
                        res.data = smaller(in_mins[in_cnt-1], out_mins[out_cnt-1]);
                    res.status = ST_DATA;
                end
            end
            CMD_SIZE:
                res.status = ST_OK;
            CMD_CLEAR:
            begin
                in_cnt     = 0;
                out_cnt    = 0;
                res.status = ST_OK;
            end
            default:
                res.status = ST_ERR;
        endcase
        res.count = CNT_W'(in_cnt + out_cnt);
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic issue(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val,
                         input logic use_fixed, input queue_result_t fixed_res);
        queue_result_t predicted;
        start   <= 1'b1;
        command <= cmd;
        value   <= val;
        do
            @(posedge clk);
        while (busy);
        queue_step(cmd, val, predicted);
        results_due.push_back(use_fixed ? fixed_res : predicted);
        sent++;
    endtask

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] val);
        issue(cmd, val, 1'b0, '0);
    endtask

    task automatic maybe_idle();
        if (sent < ITEM_TOTAL - CALM_TAIL && idle_rate != 0 && $urandom_range(1, idle_rate) == 1)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
    endtask

    function automatic logic [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return DATA_W'($signed($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] rand_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            return CMD_ENQUEUE;
        else if (pick < 68)
            return CMD_DEQUEUE;
        else if (pick < 76)
            return CMD_FRONT;
        else if (pick < 86)
            return CMD_MIN;
        else if (pick < 92)
            return CMD_SIZE;
        else if (pick < 95)
            return CMD_CLEAR;
        else
            return ($urandom_range(0, 1) == 0) ? CMD_UNKNOWN6 : CMD_UNKNOWN7;
    endfunction

    always @(posedge clk)
    begin : result_check
        queue_result_t want;
        if (rst_n && done)
        begin
            if (results_due.size() == 0)
                flag_mismatch("result with none pending", {status, data, count}, '0);
            else
            begin
                want = results_due.pop_front();
                if (status !== want.status)
                    flag_mismatch("status", status, want.status);
                if (data !== want.data)
                    flag_mismatch("data", data, want.data);
                if (count !== want.count)
                    flag_mismatch("count", count, want.count);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic filled;
        stim_row_t row;
        rst_n        = 1'b0;
        start        = 1'b0;
        command      = '0;
        value        = '0;
        in_cnt       = 0;
        out_cnt      = 0;
        mismatches   = 0;
        sent         = 0;
        idle_rate    = 4;
        quiet_cycles = 0;
        filled       = 1'b0;
        directed_rows = '{
            '{CMD_DEQUEUE,  32'h0000_0000, 1'b1, ST_ERR,  32'h0000_0000, 11'd0},
            '{CMD_FRONT,    32'h0000_0000, 1'b1, ST_ERR,  32'h0000_0000, 11'd0},
            '{CMD_MIN,      32'h0000_0000, 1'b1, ST_ERR,  32'h0000_0000, 11'd0},
            '{CMD_SIZE,     32'h0000_0000, 1'b1, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_CLEAR,    32'h0000_0000, 1'b1, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_UNKNOWN6, 32'hFFFF_FFFF, 1'b1, ST_ERR,  32'h0000_0000, 11'd0},
            '{CMD_UNKNOWN7, 32'h0000_0000, 1'b1, ST_ERR,  32'h0000_0000, 11'd0},
            '{CMD_ENQUEUE,  32'h7FFF_FFFF, 1'b1, ST_OK,   32'h0000_0000, 11'd1},
            '{CMD_MIN,      32'h0000_0000, 1'b1, ST_DATA, 32'h7FFF_FFFF, 11'd1},
            '{CMD_ENQUEUE,  32'h8000_0000, 1'b1, ST_OK,   32'h0000_0000, 11'd2},
            '{CMD_MIN,      32'h0000_0000, 1'b1, ST_DATA, 32'h8000_0000, 11'd2},
            '{CMD_FRONT,    32'h0000_0000, 1'b1, ST_DATA, 32'h7FFF_FFFF, 11'd2},
            '{CMD_ENQUEUE,  32'h0000_0000, 1'b1, ST_OK,   32'h0000_0000, 11'd3},
            '{CMD_DEQUEUE,  32'h0000_0000, 1'b1, ST_DATA, 32'h7FFF_FFFF, 11'd2},
            '{CMD_MIN,      32'h0000_0000, 1'b1, ST_DATA, 32'h8000_0000, 11'd2},
            '{CMD_ENQUEUE,  32'hFFFF_FFFF, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_MIN,      32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_FRONT,    32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_SIZE,     32'h1234_5678, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_DEQUEUE,  32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_DEQUEUE,  32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_UNKNOWN7, 32'h0000_0005, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_DEQUEUE,  32'h0000_0000, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_DEQUEUE,  32'h0000_0000, 1'b1, ST_ERR,  32'h0000_0000, 11'd0},
            '{CMD_ENQUEUE,  32'h0000_0005, 1'b0, ST_OK,   32'h0000_0000, 11'd0},
            '{CMD_CLEAR,    32'h0000_0000, 1'b1, ST_OK,   32'h0000_0000, 11'd0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = directed_rows[i];
            issue(row.cmd, row.val, row.fixed, '{row.status, row.data, row.count});
            maybe_idle();
        end
        drain();

        while (sent < ITEM_TOTAL)
        begin
            if (sent % 100 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       idle_rate = 0;
                    1:       idle_rate = 2;
                    default: idle_rate = 8;
                endcase
            end
            if (!filled && sent >= FILL_AT)
            begin
                // fill to full depth, then hit full with both stacks occupied
                while (in_cnt + out_cnt < DEPTH)
                begin
                    case ($urandom_range(0, 31))
                        0:       send(CMD_MIN, rand_value());
                        1:       send(CMD_FRONT, rand_value());
                        default: send(CMD_ENQUEUE, rand_value());
                    endcase
                    maybe_idle();
                end
                send(CMD_ENQUEUE, rand_value());
                send(CMD_MIN, rand_value());
                send(CMD_FRONT, rand_value());
                send(CMD_DEQUEUE, rand_value());
                send(CMD_ENQUEUE, rand_value());
                send(CMD_ENQUEUE, rand_value());
                send(CMD_SIZE, rand_value());
                drain();
                filled = 1'b1;
            end
            else
            begin
                send(rand_command(), rand_value());
                maybe_idle();
            end
        end

        start <= 1'b0;
        do
            @(posedge clk);
        while (results_due.size() != 0);
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/mqts_pkg.sv
rtl/min_queue_two_stacks.sv
bench/min_queue_two_stacks_test.sv
